FILE: sv/rdc_pkg.sv
// shared types, constants and helpers for the radix digit converter
// no dependencies; imported by rdc_ctrl, rdc_datapath, radix_digit_converter_core and the testbench
package rdc_pkg;

	localparam int RADIX_W     = 5;
	localparam int DIGIT_W     = 4;
	localparam int CHAR_W      = 7;
	localparam int OUT_TDATA_W = 16;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
	localparam logic [DIGIT_W-1:0] DEC_BASE    = 4'd10;
	localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'd48;
	localparam logic [CHAR_W-1:0]  ASCII_A     = 7'd65;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;      // take a new value, clear counters
		logic step;      // one restoring division bit
		logic push;      // store remainder, start next digit
		logic pop;       // read top of digit store
		logic out_load;  // move read digit into output register
	} rdc_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic div_done;   // last division bit is being taken
		logic quot_zero;  // quotient left is zero
		logic cnt_zero;   // digit store empty
		logic out_free;   // output register can take a digit
	} rdc_status_t;

	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] e;
		e = r;
		if (r < RADIX_MIN) e = RADIX_MIN;
		else if (r > RADIX_MAX) e = RADIX_MAX;
		return e;
	endfunction

	function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DEC_BASE) c = ASCII_ZERO + CHAR_W'(d);
		else c = ASCII_A + CHAR_W'(d) - CHAR_W'(DEC_BASE);
		return c;
	endfunction

endpackage

FILE: sv/rdc_ctrl.sv
// controller state machine for the radix digit converter
// depends on rdc_pkg for the command and status structs
module rdc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rdc_pkg::rdc_status_t status,
	output rdc_pkg::rdc_cmd_t    cmd
);
	import rdc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PUSH,
		ST_RD,
		ST_LOAD
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.load     = in_valid;
			ST_DIV:  cmd.step     = 1'b1;
			ST_PUSH: cmd.push     = 1'b1;
			ST_RD:   cmd.pop      = 1'b1;
			ST_LOAD: cmd.out_load = status.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_DIV;
				ST_DIV:  if (status.div_done) state_q <= ST_PUSH;
				ST_PUSH: state_q <= status.quot_zero ? ST_RD : ST_DIV;
				ST_RD:   state_q <= ST_LOAD;
				ST_LOAD: begin
					if (status.out_free) state_q <= status.cnt_zero ? ST_IDLE : ST_RD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/rdc_datapath.sv
// datapath: bit-serial restoring divider, digit store memory and output register
// depends on rdc_pkg for widths and the command and status structs
module rdc_datapath #(
	parameter int VALUE_BITS  = 31,
	parameter int STORE_DEPTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rdc_pkg::rdc_cmd_t             cmd,
	output rdc_pkg::rdc_status_t          status,
	input  logic [VALUE_BITS-1:0]         in_value,
	input  logic [rdc_pkg::RADIX_W-1:0]   radix,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [rdc_pkg::DIGIT_W-1:0]   out_digit,
	output logic                          out_last
);
	import rdc_pkg::*;

	localparam int BCNT_W = $clog2(VALUE_BITS);
	localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
	localparam int ADDR_W = $clog2(STORE_DEPTH);

	logic [VALUE_BITS-1:0] val_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [BCNT_W-1:0]     bcnt_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIGIT_W-1:0]    rd_q;
	logic                  out_valid_q;
	logic [DIGIT_W-1:0]    out_digit_q;
	logic                  out_last_q;

	logic [DIGIT_W-1:0]    store_mem [STORE_DEPTH];

	logic [RADIX_W-1:0]    trial;
	logic                  qbit;
	logic [DIGIT_W-1:0]    rem_next;
	logic [CNT_W-1:0]      cnt_dec;
	logic                  has_room;

	// restoring division, one quotient bit per cycle
	assign trial    = {rem_q, val_q[VALUE_BITS-1]};
	assign qbit     = (trial >= radix);
	assign rem_next = qbit ? DIGIT_W'(trial - radix) : trial[DIGIT_W-1:0];
	assign cnt_dec  = cnt_q - CNT_W'(1);
	assign has_room = (cnt_q < CNT_W'(STORE_DEPTH));

	assign status.div_done  = (bcnt_q == BCNT_W'(VALUE_BITS - 1));
	assign status.quot_zero = (val_q == '0);
	assign status.cnt_zero  = (cnt_q == '0);
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_digit = out_digit_q;
	assign out_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				bcnt_q <= '0;
				cnt_q  <= '0;
			end
			if (cmd.step) bcnt_q <= bcnt_q + BCNT_W'(1);
			if (cmd.push) begin
				bcnt_q <= '0;
				if (has_room) cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.pop) cnt_q <= cnt_dec;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= in_value;
			rem_q <= '0;
		end
		if (cmd.step) begin
			val_q <= {val_q[VALUE_BITS-2:0], qbit};
			rem_q <= rem_next;
		end
		if (cmd.push) rem_q <= '0;
		if (cmd.out_load) begin
			out_digit_q <= rd_q;
			out_last_q  <= status.cnt_zero;
		end
	end

	// digit store: digits beyond the depth are dropped
	always_ff @(posedge clk) begin
		if (cmd.push && has_room) store_mem[cnt_q[ADDR_W-1:0]] <= rem_q;
		if (cmd.pop) rd_q <= store_mem[cnt_dec[ADDR_W-1:0]];
	end

endmodule

FILE: sv/radix_digit_converter_core.sv
// radix digit converter: an integer in, its digits in the set radix out, most significant first
// Channels: s_axis takes one value per transfer (tdata[VALUE_BITS-1:0] = value, upper bits zero).
// m_axis gives one transfer per digit: tdata[3:0] = digit, tdata[10:4] = ASCII character,
// tlast marks the least significant, final digit. A zero value gives the single digit 0.
// cfg_valid/cfg_ready/cfg_data write the radix; values below 2 act as 2, above 16 as 16.
// Write it only while no conversion is in progress; cfg_ready is always high.
// The first digit is shown once every digit of the value has been formed; the rest follow
// one by one from the digit store while the receiver keeps tready high.
// The shared restoring divider takes one quotient bit a cycle.
// A value gives at most 31 digits with the default width (radix 2).
// s_axis_tready is high only between conversions; it rises as the final digit enters the
// output register, so the next value is taken while that digit still waits.
// A stalled receiver holds the current digit and halts the readout of the digit store.
// Reset (arst_n low) empties the converter, drops any pending digit and sets the radix to 10.
// Depends on rdc_pkg, rdc_ctrl and rdc_datapath.
module radix_digit_converter_core #(
	parameter int VALUE_BITS  = 31,
	parameter int STORE_DEPTH = 32,
	localparam int IN_TDATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [IN_TDATA_W-1:0]            s_axis_tdata,  // value
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [rdc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // digit, digit_char
	output logic                             m_axis_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rdc_pkg::RADIX_W-1:0]      cfg_data       // radix
);
	import rdc_pkg::*;

	logic [RADIX_W-1:0] radix_q;
	logic [RADIX_W-1:0] radix_eff;
	logic [DIGIT_W-1:0] digit;
	rdc_cmd_t           cmd;
	rdc_status_t        status;

	assign cfg_ready = 1'b1;
	assign radix_eff = eff_radix(radix_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_valid) begin
			radix_q <= cfg_data;
		end
	end

	rdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	rdc_datapath #(
		.VALUE_BITS  (VALUE_BITS),
		.STORE_DEPTH (STORE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_value  (s_axis_tdata[VALUE_BITS-1:0]),
		.radix     (radix_eff),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_digit (digit),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {(OUT_TDATA_W - DIGIT_W - CHAR_W)'(0), ascii_of(digit), digit};

`ifndef ASSERT_OFF
	// a value is taken only between conversions
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken while a conversion is running");

	// the character always matches the digit
	a_char_matches: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[DIGIT_W+CHAR_W-1:DIGIT_W] ==
			ascii_of(m_axis_tdata[DIGIT_W-1:0])))
		else $error("digit character does not match digit");

	// a digit that is not the last one never lets a new value in
	a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
		else $error("input ready while a run is still being read out");
`endif

endmodule

FILE: verif/tb_radix_digit_converter_core.sv
// testbench for radix_digit_converter_core: values go in, digits in the set radix come out
// a behavioral predictor queues the expected digits, a monitor checks every output transfer
// depends on rdc_pkg and radix_digit_converter_core
`timescale 1ns / 100ps

module tb_radix_digit_converter_core;
	import rdc_pkg::*;

	localparam int VALUE_W     = 31;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int IDLE_PCT    = 26;
	localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic [CHAR_W-1:0]  digit_char;
		logic               last_digit;
	} digit_rec_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [31:0]            s_axis_tdata = '0;   // value, pad bit
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // digit, digit_char, pad bits
	logic                   m_axis_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [RADIX_W-1:0]     cfg_data = '0;       // radix

	digit_rec_t         digits_due[$];
	logic [RADIX_W-1:0] radix_setting = RADIX_RESET;
	bit                 no_gaps = 1'b0;
	int                 mismatches = 0;
	int                 values_sent = 0;
	int                 digits_checked = 0;
	int                 radix_writes = 0;
	int                 cycle_count = 0;

	radix_digit_converter_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// expected digits of one value, most significant first
	function automatic void queue_digits(input logic [VALUE_W-1:0] value);
		logic [RADIX_W-1:0] base;
		logic [VALUE_W-1:0] rest;
		logic [DIGIT_W-1:0] lsd_first[$];
		logic [DIGIT_W-1:0] d;
		digit_rec_t         rec;
		base = radix_setting;
		if (base < RADIX_MIN) base = RADIX_MIN;
		else if (base > RADIX_MAX) base = RADIX_MAX;
		rest = value;
		// zero still gives one digit
		do begin
			lsd_first.push_back(DIGIT_W'(rest % base));
			rest = rest / base;
		end while (rest != 0);
		for (int i = lsd_first.size() - 1; i >= 0; i--) begin
			d = lsd_first[i];
			rec.digit      = d;
			rec.digit_char = (d < 10) ? CHAR_W'("0" + d) : CHAR_W'("A" + d - 10);
			rec.last_digit = (i == 0);
			digits_due.push_back(rec);
		end
	endfunction

	task automatic check_digit();
		digit_rec_t want;
		if (digits_due.size() == 0) begin
			$error("digit transfer with nothing expected: tdata %h tlast %b",
				m_axis_tdata, m_axis_tlast);
			mismatches++;
		end else begin
			want = digits_due.pop_front();
			digits_checked++;
			if (m_axis_tdata[3:0] !== want.digit) begin
				$error("digit: expected %0d, got %0d", want.digit, m_axis_tdata[3:0]);
				mismatches++;
			end
			if (m_axis_tdata[10:4] !== want.digit_char) begin
				$error("digit_char: expected %0d, got %0d", want.digit_char,
					m_axis_tdata[10:4]);
				mismatches++;
			end
			if (m_axis_tlast !== want.last_digit) begin
				$error("last_digit: expected %0d, got %0d", want.last_digit, m_axis_tlast);
				mismatches++;
			end
		end
	endtask

	// output monitor and receiver backpressure
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) check_digit();
		m_axis_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
	end

	task automatic send_value(input logic [VALUE_W-1:0] value);
		if (!no_gaps) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, value};
		do @(posedge clk); while (!s_axis_tready);
		queue_digits(value);
		values_sent++;
	endtask

	// hold input off until every expected digit has come out
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (digits_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_radix(input logic [RADIX_W-1:0] r);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= r;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		radix_setting = r;
		radix_writes++;
	endtask

	function automatic logic [VALUE_W-1:0] random_value();
		int pick;
		pick = $urandom_range(19);
		if (pick == 0) return '0;
		if (pick == 1) return VALUE_MAX;
		// spread the magnitudes so digit counts vary
		return VALUE_W'($urandom()) >> $urandom_range(VALUE_W - 1);
	endfunction

	// reset radix of 10, zero, single digits and the widest value
	task automatic test_reset_radix();
		send_value('0);
		send_value(1);
		send_value(9);
		send_value(10);
		send_value(1234567890);
		send_value(VALUE_MAX);
	endtask

	// extreme and out-of-range radices, letter digits
	task automatic test_radix_edges();
		write_radix(RADIX_MIN);
		send_value('0);
		send_value(VALUE_MAX);
		send_value(31'h4000_0000);
		write_radix(RADIX_MAX);
		send_value(31'h00FE_DCBA);
		send_value(15);
		send_value(VALUE_MAX);
		write_radix(5'd0);
		send_value(5);
		write_radix(5'd1);
		send_value(3);
		write_radix(5'd31);
		send_value(31'h7FED_CBA9);
		write_radix(5'd17);
		send_value(255);
		write_radix(5'd11);
		send_value(10);
		write_radix(5'd15);
		send_value(14);
		write_radix(5'd3);
		send_value(VALUE_MAX);
	endtask

	task automatic test_random_values();
		for (int phase = 0; phase < 8; phase++) begin
			write_radix(RADIX_W'($urandom_range(31)));
			no_gaps = (phase == 3);
			for (int i = 0; i < 19; i++) begin
				send_value(random_value());
				if (i == 9 && phase == 5) wait_idle();
			end
			no_gaps = 1'b0;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_radix();
		test_radix_edges();
		test_random_values();
		wait_idle();
		repeat (40) @(posedge clk);
		$display("tb: %0d values converted, %0d digits checked, %0d radix writes",
			values_sent, digits_checked, radix_writes);
		$display("tb: radices below 2 and above 16 included, with and without stalls");
		if (mismatches == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

FILE: sim.f
sv/rdc_pkg.sv
sv/rdc_ctrl.sv
sv/rdc_datapath.sv
sv/radix_digit_converter_core.sv
verif/tb_radix_digit_converter_core.sv
